@@ hdl/rbfi_pkg.sv @@
// Package for the rigid body friction integrator.
// Holds the sequencer state type, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package rbfi_pkg;

  localparam int unsigned RegW  = 31;  // config register width
  localparam int unsigned IdxW  = 3;   // config index width
  localparam int unsigned DivIt = 48;  // quotient bits of force / mass
  localparam int unsigned SqrIt = 32;  // root bits / friction quotient bits

  localparam logic [IdxW-1:0] REG_MASS     = 3'd0;
  localparam logic [IdxW-1:0] REG_FRICTION = 3'd1;
  localparam logic [IdxW-1:0] REG_MAX_X    = 3'd2;
  localparam logic [IdxW-1:0] REG_MAX_Y    = 3'd3;

  localparam logic [RegW-1:0] MASS_RST     = 31'd65536;
  localparam logic [RegW-1:0] FRICTION_RST = 31'd6553600;
  localparam logic [RegW-1:0] MAX_X_RST    = 31'd13107200;
  localparam logic [RegW-1:0] MAX_Y_RST    = 31'd39321600;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_ACCEL,
    ST_VMUL,
    ST_VUPD,
    ST_CHECK,
    ST_FRMUL,
    ST_SQ,
    ST_SQACC,
    ST_SQRT,
    ST_CMP,
    ST_FMUL,
    ST_FDIV_LOAD,
    ST_FDIV_RUN,
    ST_FEND,
    ST_CLAMP,
    ST_PMUL,
    ST_PUPD,
    ST_OUT
  } state_e;

endpackage

@@ hdl/rigid_body_friction_integrator.sv @@
// Top level of the rigid body friction integrator (semi-implicit Euler step, Q16.16).
// Depends on rbfi_pkg.
`timescale 1ns / 1ps

// One input beat is one simulation tick for one body: force, extra acceleration and
// a Q0.16 time step. The block keeps velocity and position, and returns one output
// beat with the new position and velocity. Work is done by a small sequencer around
// one shared 33x33 multiplier and one shared shift-subtract unit that does both the
// restoring divides and the square root, one quotient or root bit per cycle.
// Steps in order: force/mass and velocity update per component, the zero check, the
// friction term and the squares, the speed root and compare, the friction correction,
// and clamp, position and the output load; the sequencer then returns to idle, where
// the next beat is taken. The divide of a zero force component is skipped; the
// friction term, squares, root and correction are skipped when the velocity is zero,
// and the correction is skipped when friction stops the body.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next beat can be taken while it
// waits; a finished beat waits in the sequencer only while an older one is unread.
// Config writes are always accepted and must only happen while idle.

module rigid_body_friction_integrator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // force_x, force_y, force_z, extra_accel_x, extra_accel_y, extra_accel_z,
  // tick_seconds (low bits first)
  input  logic [207:0] s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (low bits first)
  output logic [191:0] m_axis_tdata
);

  // config registers
  logic [30:0] mass_q, fric_q, maxx_q, maxy_q;

  // latched inputs
  logic signed [31:0] force_q [3];
  logic signed [31:0] eacc_q  [3];
  logic        [15:0] dt_q;

  // body state
  logic signed [31:0] vel_q [3];
  logic signed [31:0] pos_q [3];

  // sequencer
  rbfi_pkg::state_e state_q, state_d;
  logic [1:0] idx_q;
  logic [5:0] cnt_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod_q;

  // shared shift-subtract unit (divide / square root)
  logic        sqrt_q;   // 1: root step, 0: divide step
  logic [34:0] rem_q;
  logic [63:0] sh_q;
  logic [47:0] q_q;
  logic [31:0] dvs_q;
  logic        neg_q;

  // misc datapath
  logic signed [31:0] acc_q;  // acceleration of current component
  logic [31:0] fr_q;          // friction delta-v this tick
  logic [31:0] spd_q;         // speed
  logic [63:0] sum_q;         // sum of squares

  logic [191:0] out_q;
  logic         m_valid_q;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -34'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic [32:0] mag;
    mag = v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    if (mag > {2'b0, lim}) return v[31] ? 32'(-{1'b0, lim}) : {1'b0, lim};
    else                   return v;
  endfunction

  // ---- shift-subtract step ----
  logic [34:0] ss_cand, ss_opnd;
  logic [35:0] ss_diff;
  logic        ss_ge;

  always_comb begin
    if (sqrt_q) begin
      ss_cand = {rem_q[32:0], sh_q[63:62]};
      ss_opnd = {1'b0, q_q[31:0], 2'b01};
    end else begin
      ss_cand = {rem_q[33:0], sh_q[63]};
      ss_opnd = {3'b0, dvs_q};
    end
    ss_diff = {1'b0, ss_cand} - {1'b0, ss_opnd};
    ss_ge   = !ss_diff[35];
  end

  // ---- force term and acceleration ----
  logic signed [32:0] term;
  logic signed [33:0] acc_sum;
  logic [31:0]        fabs;
  logic signed [31:0] fcur;

  always_comb begin
    fcur = force_q[idx_q];
    fabs = fcur[31] ? 32'(-{fcur[31], fcur}) : fcur;
    if (!neg_q) begin
      term = (q_q > 48'h0000_7FFF_FFFF) ? 33'sh0_7FFF_FFFF : {1'b0, q_q[31:0]};
    end else begin
      term = (q_q > 48'h0000_8000_0000) ? -33'sh0_8000_0000 : 33'(-{1'b0, q_q[31:0]});
    end
    acc_sum = {term[32], term} + {{2{eacc_q[idx_q][31]}}, eacc_q[idx_q]};
  end

  // ---- multiplier operand select ----
  always_comb begin
    mul_a = {acc_q[31], acc_q};
    mul_b = {17'b0, dt_q};
    unique case (state_q)
      rbfi_pkg::ST_VMUL: begin
        mul_a = {acc_q[31], acc_q};
        mul_b = {17'b0, dt_q};
      end
      rbfi_pkg::ST_FRMUL: begin
        mul_a = {2'b0, fric_q};
        mul_b = {17'b0, dt_q};
      end
      rbfi_pkg::ST_SQ: begin
        mul_a = {vel_q[idx_q][31], vel_q[idx_q]};
        mul_b = mul_a;
      end
      rbfi_pkg::ST_FMUL: begin
        mul_a = {vel_q[idx_q][31], vel_q[idx_q]};
        mul_b = {1'b0, fr_q};
      end
      rbfi_pkg::ST_PMUL: begin
        mul_a = {vel_q[idx_q][31], vel_q[idx_q]};
        mul_b = {17'b0, dt_q};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---- handshake outputs ----
  always_comb begin
    s_axis_tready = (state_q == rbfi_pkg::ST_IDLE);
    cfg_ready_o   = 1'b1;
    m_axis_tvalid = m_valid_q;
    m_axis_tdata  = out_q;
  end

  logic vel_zero;
  logic out_free;
  assign vel_zero = (vel_q[0] == '0) && (vel_q[1] == '0) && (vel_q[2] == '0);
  assign out_free = !m_valid_q || m_axis_tready;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbfi_pkg::ST_IDLE:      if (s_axis_tvalid) state_d = rbfi_pkg::ST_DIV_LOAD;
      rbfi_pkg::ST_DIV_LOAD:  state_d = (fcur == '0) ? rbfi_pkg::ST_ACCEL : rbfi_pkg::ST_DIV_RUN;
      rbfi_pkg::ST_DIV_RUN:   if (cnt_q == 6'd1) state_d = rbfi_pkg::ST_ACCEL;
      rbfi_pkg::ST_ACCEL:     state_d = rbfi_pkg::ST_VMUL;
      rbfi_pkg::ST_VMUL:      state_d = rbfi_pkg::ST_VUPD;
      rbfi_pkg::ST_VUPD:      state_d = (idx_q == 2'd2) ? rbfi_pkg::ST_CHECK
                                                         : rbfi_pkg::ST_DIV_LOAD;
      rbfi_pkg::ST_CHECK:     state_d = vel_zero ? rbfi_pkg::ST_CLAMP : rbfi_pkg::ST_FRMUL;
      rbfi_pkg::ST_FRMUL:     state_d = rbfi_pkg::ST_SQ;
      rbfi_pkg::ST_SQ:        if (idx_q == 2'd2) state_d = rbfi_pkg::ST_SQACC;
      rbfi_pkg::ST_SQACC:     state_d = rbfi_pkg::ST_SQRT;
      rbfi_pkg::ST_SQRT:      if (cnt_q == 6'd1) state_d = rbfi_pkg::ST_CMP;
      rbfi_pkg::ST_CMP:       state_d = (q_q[31:0] <= fr_q) ? rbfi_pkg::ST_CLAMP
                                                             : rbfi_pkg::ST_FMUL;
      rbfi_pkg::ST_FMUL:      state_d = rbfi_pkg::ST_FDIV_LOAD;
      rbfi_pkg::ST_FDIV_LOAD: state_d = rbfi_pkg::ST_FDIV_RUN;
      rbfi_pkg::ST_FDIV_RUN:  if (cnt_q == 6'd1) state_d = rbfi_pkg::ST_FEND;
      rbfi_pkg::ST_FEND:      state_d = (idx_q == 2'd2) ? rbfi_pkg::ST_CLAMP
                                                         : rbfi_pkg::ST_FMUL;
      rbfi_pkg::ST_CLAMP:     state_d = rbfi_pkg::ST_PMUL;
      rbfi_pkg::ST_PMUL:      state_d = rbfi_pkg::ST_PUPD;
      rbfi_pkg::ST_PUPD:      state_d = (idx_q == 2'd2) ? rbfi_pkg::ST_OUT
                                                         : rbfi_pkg::ST_PMUL;
      rbfi_pkg::ST_OUT:       if (out_free) state_d = rbfi_pkg::ST_IDLE;
      default:                state_d = rbfi_pkg::ST_IDLE;
    endcase
  end

  // ---- config registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= rbfi_pkg::MASS_RST;
      fric_q <= rbfi_pkg::FRICTION_RST;
      maxx_q <= rbfi_pkg::MAX_X_RST;
      maxy_q <= rbfi_pkg::MAX_Y_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rbfi_pkg::REG_MASS:     mass_q <= cfg_data_i;
        rbfi_pkg::REG_FRICTION: fric_q <= cfg_data_i;
        rbfi_pkg::REG_MAX_X:    maxx_q <= cfg_data_i;
        rbfi_pkg::REG_MAX_Y:    maxy_q <= cfg_data_i;
        default:                ;  // unknown index ignored
      endcase
    end
  end

  // ---- control and state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rbfi_pkg::ST_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // a new result replaces the one leaving in the same cycle
      if ((state_q == rbfi_pkg::ST_OUT) && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)                        m_valid_q <= 1'b0;
      unique case (state_q)
        rbfi_pkg::ST_IDLE:      idx_q <= '0;
        rbfi_pkg::ST_DIV_LOAD:  cnt_q <= 6'(rbfi_pkg::DivIt);
        rbfi_pkg::ST_DIV_RUN,
        rbfi_pkg::ST_SQRT,
        rbfi_pkg::ST_FDIV_RUN:  cnt_q <= cnt_q - 6'd1;
        rbfi_pkg::ST_VUPD: begin
          vel_q[idx_q] <= sat32({{2{vel_q[idx_q][31]}}, vel_q[idx_q]} +
                                34'(prod_q >>> 16));
          idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        rbfi_pkg::ST_SQ:        idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        rbfi_pkg::ST_SQACC:     cnt_q <= 6'(rbfi_pkg::SqrIt);
        rbfi_pkg::ST_CMP: begin
          if (q_q[31:0] <= fr_q) begin
            for (int i = 0; i < 3; i++) vel_q[i] <= '0;  // friction stops the body
          end
        end
        rbfi_pkg::ST_FDIV_LOAD: cnt_q <= 6'(rbfi_pkg::SqrIt);
        rbfi_pkg::ST_FEND: begin
          vel_q[idx_q] <= neg_q ? vel_q[idx_q] + signed'(q_q[31:0])
                                : vel_q[idx_q] - signed'(q_q[31:0]);
          idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        rbfi_pkg::ST_CLAMP: begin
          vel_q[0] <= clamp_mag(vel_q[0], maxx_q);
          vel_q[1] <= clamp_mag(vel_q[1], maxy_q);
          idx_q    <= '0;
        end
        rbfi_pkg::ST_PUPD: begin
          pos_q[idx_q] <= sat32({{2{pos_q[idx_q][31]}}, pos_q[idx_q]} +
                                34'(prod_q >>> 16));
          idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        default:                ;
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];
    unique case (state_q)
      rbfi_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            force_q[i] <= s_axis_tdata[32*i +: 32];
            eacc_q[i]  <= s_axis_tdata[96 + 32*i +: 32];
          end
          dt_q <= s_axis_tdata[207:192];
        end
      end
      rbfi_pkg::ST_DIV_LOAD: begin
        // |f| << 16 sits in the top 48 bits of the shifter
        sqrt_q <= 1'b0;
        rem_q  <= '0;
        sh_q   <= {fabs, 32'b0};
        q_q    <= '0;
        dvs_q  <= {1'b0, mass_q};
        neg_q  <= fcur[31];
      end
      rbfi_pkg::ST_DIV_RUN,
      rbfi_pkg::ST_SQRT,
      rbfi_pkg::ST_FDIV_RUN: begin
        rem_q <= ss_ge ? ss_diff[34:0] : ss_cand;
        sh_q  <= sqrt_q ? {sh_q[61:0], 2'b0} : {sh_q[62:0], 1'b0};
        q_q   <= {q_q[46:0], ss_ge};
      end
      rbfi_pkg::ST_ACCEL:     acc_q <= sat32(acc_sum);
      rbfi_pkg::ST_SQ: begin
        if (idx_q == 2'd0) begin
          fr_q  <= {1'b0, prod_q[46:16]};  // product of fric and dt
          sum_q <= '0;
        end else begin
          sum_q <= sum_q + prod_q;
        end
      end
      rbfi_pkg::ST_SQACC: begin
        sqrt_q <= 1'b1;
        rem_q  <= '0;
        sh_q   <= sum_q + prod_q;
        q_q    <= '0;
      end
      rbfi_pkg::ST_CMP:       spd_q <= q_q[31:0];
      rbfi_pkg::ST_FDIV_LOAD: begin
        // quotient of |v*fr| / spd is below 2^32, so the high word starts as remainder
        sqrt_q <= 1'b0;
        neg_q  <= prod_q[63];
        if (prod_q[63]) begin
          rem_q <= {3'b0, 32'(64'(-prod_q) >> 32)};
          sh_q  <= {32'(-prod_q), 32'b0};
        end else begin
          rem_q <= {3'b0, prod_q[63:32]};
          sh_q  <= {prod_q[31:0], 32'b0};
        end
        q_q   <= '0;
        dvs_q <= spd_q;
      end
      rbfi_pkg::ST_OUT: begin
        if (out_free) begin
          out_q <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
        end
      end
      default: ;
    endcase
  end

endmodule
